>>> sv/longest_decreasing_gap_subsequence_macros.svh
// Assertion macros shared by the longest decreasing gap subsequence RTL.
`ifndef LONGEST_DECREASING_GAP_SUBSEQUENCE_MACROS_SVH
`define LONGEST_DECREASING_GAP_SUBSEQUENCE_MACROS_SVH

`ifndef SYNTHESIS
`define LDGS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ldgs assertion failed");
`define LDGS_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ldgs forbidden condition seen");
`else
`define LDGS_ASSERT(label, clk, rst, prop)
`define LDGS_NEVER(label, clk, rst, cond)
`endif

`endif

>>> sv/ldgs_pkg.sv
// Shared constants, types and helpers for the longest decreasing gap subsequence block.
package ldgs_pkg;

   localparam int VALUE_COUNT = 256;
   localparam int VAL_W       = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
   localparam int ADDR_W      = 2 * VAL_W;
   localparam int TBL_DEPTH   = 1 << ADDR_W;
   localparam int LEN_W       = 16;
   localparam int EPOCH_W     = 8;
   localparam int ENTRY_W     = EPOCH_W + LEN_W;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic issue;
      logic publish;
   } ldgs_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic d_zero;
      logic in_range;
      logic epoch_last;
      logic out_free;
   } ldgs_stat_type;

   function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] r;
      r = (&v) ? v : v + 1'b1;
      return r;
   endfunction

endpackage

>>> sv/longest_decreasing_gap_subsequence.sv
// Items are taken one at a time: req_ready is high only in the idle state, so a
// new item waits until the previous one is published. The gap sweep does one
// table update per cycle over two RAM read ports and one write port.
// Reset: synchronous, active high; a clearing pass over the whole table
// follows, and the same pass runs once every 256 set starts.
// Top level of the longest decreasing gap subsequence block.
module longest_decreasing_gap_subsequence
   import ldgs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_value,
   input  logic              req_starts_set,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [LEN_W-1:0]  rsp_best_length
);

   ldgs_cmd_type  cmd;
   ldgs_stat_type stat;

   ldgs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_starts_set (req_starts_set),
      .req_ready      (req_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   ldgs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .req_starts_set  (req_starts_set),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_best_length (rsp_best_length),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

>>> sv/ldgs_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module ldgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic [WIDTH-1:0]           rd_data_a,
   output logic [WIDTH-1:0]           rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

>>> sv/ldgs_ctrl.sv
// Controller state machine: table clearing, per-item gap sweep and result hand-off.
`include "longest_decreasing_gap_subsequence_macros.svh"

module ldgs_ctrl
   import ldgs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_starts_set,
   output logic          req_ready,
   input  ldgs_stat_type stat,
   output ldgs_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_SWEEP,
      ST_DRAIN,
      ST_PUBLISH
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.load     = req_valid && req_ready;
      cmd.clr_step = (state_ff == ST_CLEAR);
      cmd.issue    = (state_ff == ST_SWEEP);
      cmd.publish  = (state_ff == ST_PUBLISH) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) begin
               state_in = pend_ff ? ST_START : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (cmd.load) begin
               if (req_starts_set && stat.epoch_last) begin
                  state_in = ST_CLEAR;
                  pend_in  = 1'b1;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            state_in = stat.in_range ? ST_SWEEP : ST_PUBLISH;
         end
         ST_SWEEP: begin
            if (stat.d_zero) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   `LDGS_ASSERT(a_cmd_onehot, clock, reset, $onehot0({cmd.load, cmd.clr_step, cmd.issue, cmd.publish}))
   `LDGS_ASSERT(a_sweep_end, clock, reset, (state_ff == ST_SWEEP && stat.d_zero) |=> (state_ff == ST_DRAIN))
   `LDGS_ASSERT(a_wrap_clears, clock, reset, (cmd.load && req_starts_set && stat.epoch_last) |=> (state_ff == ST_CLEAR))

endmodule

>>> sv/ldgs_dp.sv
// Datapath: length table RAM, gap counter, running candidate, best length and result register.
`include "longest_decreasing_gap_subsequence_macros.svh"

module ldgs_dp
   import ldgs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_value,
   input  logic              req_starts_set,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [LEN_W-1:0]  rsp_best_length,
   input  ldgs_cmd_type      cmd,
   output ldgs_stat_type     stat
);

   logic [VAL_W-1:0]   x_ff, x_in;
   logic               in_range_ff, in_range_in;
   logic [VAL_W-1:0]   d_ff, d_in;
   logic [VAL_W-1:0]   dq_ff;
   logic               ok0_ff, ok1_ff;
   logic               rd_vld_ff;
   logic [LEN_W-1:0]   t_ff, t_in;
   logic [LEN_W-1:0]   best_ff, best_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic               rsp_valid_ff;
   logic [LEN_W-1:0]   rsp_len_ff;

   logic [VAL_W:0]     sum_up;
   logic [VAL_W-1:0]   row_up, row_dn;
   logic               ok0, ok1;
   logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b, wr_addr;
   logic [ENTRY_W-1:0] rd_data_a, rd_data_b, wr_data;
   logic               wr_en;
   logic [LEN_W-1:0]   c0, c1, t_new;

   assign sum_up = {1'b0, x_ff} + {1'b0, d_ff};
   assign ok0    = sum_up < (VAL_W+1)'(VALUE_COUNT);
   assign ok1    = x_ff >= d_ff;
   assign row_up = sum_up[VAL_W-1:0];
   assign row_dn = x_ff - d_ff;

   assign rd_addr_a = {row_up, d_ff};
   assign rd_addr_b = {row_dn, d_ff};

   always_comb begin
      c0 = (ok0_ff && rd_data_a[ENTRY_W-1:LEN_W] == epoch_ff) ?
           sat_inc(rd_data_a[LEN_W-1:0]) : '0;
      c1 = (ok1_ff && rd_data_b[ENTRY_W-1:LEN_W] == epoch_ff) ?
           sat_inc(rd_data_b[LEN_W-1:0]) : '0;
      t_new = t_ff;
      if (c0 > t_new) begin
         t_new = c0;
      end
      if (c1 > t_new) begin
         t_new = c1;
      end
   end

   assign wr_en   = cmd.clr_step || rd_vld_ff;
   assign wr_addr = cmd.clr_step ? clr_addr_ff : {x_ff, dq_ff};
   assign wr_data = cmd.clr_step ? '0 : {epoch_ff, t_new};

   ldgs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      x_in        = x_ff;
      in_range_in = in_range_ff;
      d_in        = d_ff;
      t_in        = t_ff;
      best_in     = best_ff;
      epoch_in    = epoch_ff;
      if (cmd.load) begin
         x_in        = VAL_W'(req_value);
         in_range_in = 32'(req_value) < VALUE_COUNT;
         d_in        = VAL_W'(VALUE_COUNT - 1);
         t_in        = LEN_W'(1);
         if (req_starts_set) begin
            best_in  = '0;
            epoch_in = epoch_ff + 1'b1;
         end
      end else begin
         if (cmd.issue) begin
            d_in = d_ff - 1'b1;
         end
         if (rd_vld_ff) begin
            t_in = t_new;
            if (t_new > best_ff) begin
               best_in = t_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         best_ff      <= '0;
         epoch_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         best_ff   <= best_in;
         epoch_ff  <= epoch_in;
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      in_range_ff <= in_range_in;
      d_ff        <= d_in;
      t_ff        <= t_in;
      dq_ff       <= d_ff;
      ok0_ff      <= ok0;
      ok1_ff      <= ok1;
      if (cmd.publish) begin
         rsp_len_ff <= best_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_length = rsp_len_ff;

   always_comb begin
      stat            = '0;
      stat.clr_last   = &clr_addr_ff;
      stat.d_zero     = (d_ff == '0);
      stat.in_range   = in_range_ff;
      stat.epoch_last = &epoch_ff;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   `LDGS_ASSERT(a_t_grows, clock, reset, rd_vld_ff |=> (t_ff >= $past(t_ff)))
   `LDGS_ASSERT(a_best_covers_t, clock, reset, rd_vld_ff |=> (best_ff >= t_ff))
   `LDGS_NEVER(a_no_overwrite, clock, reset, cmd.publish && rsp_valid_ff && !rsp_ready)

endmodule
